FILE: sv/gdda_pkg.sv
package gdda_pkg;

  // fixed field and datapath widths
  localparam int PIX_W    = 20;
  localparam int DFRAC    = 16;
  localparam int POS_W    = PIX_W + DFRAC;
  localparam int DIR_W    = 24;
  localparam int LEN_W    = 25;
  localparam int STEP_W   = 41;
  localparam int CROSS_W  = 42;
  localparam int DIST_W   = 26;
  localparam int CELL_W   = 22;
  localparam int SQ_W     = 50;
  localparam int DIV_N_W  = 50;
  localparam int DIV_D_W  = 25;
  localparam int MUL_A_W  = 24;
  localparam int MUL_B_W  = 41;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int FLD_W    = 7;
  localparam int TOT_W    = 5;

  localparam logic [STEP_W-1:0] STEP_CAP = {1'b1, {(STEP_W-1){1'b0}}};
  localparam logic [PIX_W-1:0]  PIX_MAX  = {PIX_W{1'b1}};

  // register indexes
  localparam logic [1:0] REG_SHIFT_X = 2'd0;
  localparam logic [1:0] REG_SHIFT_Y = 2'd1;
  localparam logic [1:0] REG_MAX_DST = 2'd2;

  typedef enum logic [1:0] {
    Q_WRITE,
    Q_CAST,
    Q_NULL
  } q_kind_t;

  typedef struct packed {
    q_kind_t              kind;
    logic [FLD_W-1:0]     col;
    logic [FLD_W-1:0]     row;
    logic                 solid;
    logic [POS_W-1:0]     ox;
    logic [POS_W-1:0]     oy;
    logic [POS_W-1:0]     ux;
    logic [POS_W-1:0]     uy;
    logic                 negx;
    logic                 negy;
  } q_entry_t;

  typedef struct packed {
    logic [3:0] sx;
    logic [3:0] sy;
    logic [7:0] max_dist;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

  typedef enum logic [4:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_NORM,
    BK_SQX,
    BK_SQY,
    BK_SQS,
    BK_SQRT,
    BK_DX_GO,
    BK_DX_WAIT,
    BK_DY_GO,
    BK_DY_WAIT,
    BK_CRX,
    BK_CRY,
    BK_CRD,
    BK_WALK,
    BK_TEST,
    BK_MX,
    BK_OX_GO,
    BK_OX_WAIT,
    BK_MY,
    BK_OY_GO,
    BK_OY_WAIT,
    BK_FIN,
    BK_OUT
  } bk_state_t;

endpackage

FILE: sv/grid_dda_ray_cast_top.sv
// write transaction: popped from the queue in the idle state, its result is registered in the output state
// ray transaction: setup (direction scaling, a square root, one division per axis
// with nonzero direction), then a walk of one cell per step, and two more divisions
// on a hit
// one transaction is worked at a time by the back end; the two-entry queue holds the next
// reset is synchronous and returns configuration to shift 5, 5 and limit 100; after it
// the tile map is cleared entry by entry with input stalled
module grid_dda_ray_cast_top #(
  parameter int GRID_COLS       = 128,
  parameter int GRID_ROWS       = 128,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [gdda_pkg::FLD_W-1:0]     in_cell_col,
  input  logic [gdda_pkg::FLD_W-1:0]     in_cell_row,
  input  logic                           in_solid,
  input  logic [gdda_pkg::PIX_W-1:0]     in_start_x,
  input  logic [gdda_pkg::PIX_W-1:0]     in_start_y,
  input  logic [gdda_pkg::PIX_W-1:0]     in_end_x,
  input  logic [gdda_pkg::PIX_W-1:0]     in_end_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit,
  output logic [gdda_pkg::PIX_W-1:0]     out_hit_x,
  output logic [gdda_pkg::PIX_W-1:0]     out_hit_y,
  output logic [gdda_pkg::FLD_W-1:0]     out_hit_col,
  output logic [gdda_pkg::FLD_W-1:0]     out_hit_row,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import gdda_pkg::*;

  cfg_t     cfg_r;
  q_entry_t f_entry, q_rdata;
  q_ctl_t   q_ctl;
  q_sts_t   q_sts;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     f_push, b_pop, clearing;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sx       <= 4'd5;
      cfg_r.sy       <= 4'd5;
      cfg_r.max_dist <= 8'd100;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_SHIFT_X: cfg_r.sx       <= pwdata[3:0];
        REG_SHIFT_Y: cfg_r.sy       <= pwdata[3:0];
        REG_MAX_DST: cfg_r.max_dist <= pwdata[7:0];
        default:     cfg_r.sx       <= cfg_r.sx;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SHIFT_X: prdata = {28'b0, cfg_r.sx};
      REG_SHIFT_Y: prdata = {28'b0, cfg_r.sy};
      REG_MAX_DST: prdata = {24'b0, cfg_r.max_dist};
      default:     prdata = 32'b0;
    endcase
  end

  assign q_ctl.push = f_push;
  assign q_ctl.pop  = b_pop;

  gdda_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_cell_col (in_cell_col),
    .in_cell_row (in_cell_row),
    .in_solid    (in_solid),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .cfg         (cfg_r),
    .q_full      (q_sts.full),
    .clearing    (clearing),
    .in_stall    (in_stall),
    .push        (f_push),
    .entry       (f_entry)
  );

  gdda_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (q_ctl),
    .wdata (f_entry),
    .sts   (q_sts),
    .rdata (q_rdata)
  );

  gdda_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gdda_back #(
    .GRID_COLS      (GRID_COLS),
    .GRID_ROWS      (GRID_ROWS),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_sts       (q_sts),
    .q_data      (q_rdata),
    .q_pop       (b_pop),
    .clearing    (clearing),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_hit     (out_hit),
    .out_hit_x   (out_hit_x),
    .out_hit_y   (out_hit_y),
    .out_hit_col (out_hit_col),
    .out_hit_row (out_hit_row)
  );

endmodule

FILE: sv/gdda_front.sv
module gdda_front #(
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                           in_valid,
  input  logic                           in_req_type,
  input  logic [gdda_pkg::FLD_W-1:0]     in_cell_col,
  input  logic [gdda_pkg::FLD_W-1:0]     in_cell_row,
  input  logic                           in_solid,
  input  logic [gdda_pkg::PIX_W-1:0]     in_start_x,
  input  logic [gdda_pkg::PIX_W-1:0]     in_start_y,
  input  logic [gdda_pkg::PIX_W-1:0]     in_end_x,
  input  logic [gdda_pkg::PIX_W-1:0]     in_end_y,
  input  gdda_pkg::cfg_t                 cfg,
  input  logic                           q_full,
  input  logic                           clearing,
  output logic                           in_stall,
  output logic                           push,
  output gdda_pkg::q_entry_t             entry
);
  import gdda_pkg::*;

  logic [TOT_W-1:0] totx, toty;
  logic [POS_W-1:0] ox, oy, tx, ty;

  // pixels to tile units
  assign totx = TOT_W'(COORD_FRAC_BITS) + TOT_W'(cfg.sx);
  assign toty = TOT_W'(COORD_FRAC_BITS) + TOT_W'(cfg.sy);
  assign ox = {in_start_x, {DFRAC{1'b0}}} >> totx;
  assign oy = {in_start_y, {DFRAC{1'b0}}} >> toty;
  assign tx = {in_end_x, {DFRAC{1'b0}}} >> totx;
  assign ty = {in_end_y, {DFRAC{1'b0}}} >> toty;

  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  // classify the transaction and form direction magnitudes
  always_comb begin
    entry.col   = in_cell_col;
    entry.row   = in_cell_row;
    entry.solid = in_solid;
    entry.ox    = ox;
    entry.oy    = oy;
    entry.negx  = tx < ox;
    entry.negy  = ty < oy;
    entry.ux    = (tx < ox) ? (ox - tx) : (tx - ox);
    entry.uy    = (ty < oy) ? (oy - ty) : (ty - oy);
    if (!in_req_type) begin
      entry.kind = Q_WRITE;
    end else if (ox == tx && oy == ty) begin
      entry.kind = Q_NULL;
    end else begin
      entry.kind = Q_CAST;
    end
  end

endmodule

FILE: sv/gdda_queue.sv
module gdda_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  gdda_pkg::q_ctl_t    ctl,
  input  gdda_pkg::q_entry_t  wdata,
  output gdda_pkg::q_sts_t    sts,
  output gdda_pkg::q_entry_t  rdata
);
  import gdda_pkg::*;

  q_entry_t   slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign sts.full  = cnt_r == 2'd2;
  assign sts.empty = cnt_r == 2'd0;
  assign rdata     = slot_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.push && !ctl.pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!ctl.push && ctl.pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // two-entry queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (ctl.push) begin
        wptr_r <= ~wptr_r;
      end
      if (ctl.pop) begin
        rptr_r <= ~rptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: sv/gdda_div.sv
module gdda_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gdda_pkg::div_req_t req,
  output gdda_pkg::div_rsp_t rsp
);
  import gdda_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_D_W-1:0] den_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_N_W-1:0] q_r;
  logic [DIV_D_W:0]   trial;
  logic               ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, q_r[DIV_N_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r <= req.den;
      rem_r <= '0;
      q_r   <= req.num;
    end else if (busy_r) begin
      rem_r <= ge ? DIV_D_W'(trial - {1'b0, den_r}) : trial[DIV_D_W-1:0];
      q_r   <= {q_r[DIV_N_W-2:0], ge};
    end
  end

endmodule

FILE: sv/gdda_back.sv
module gdda_back #(
  parameter int GRID_COLS       = 128,
  parameter int GRID_ROWS       = 128,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gdda_pkg::cfg_t                 cfg,
  input  gdda_pkg::q_sts_t               q_sts,
  input  gdda_pkg::q_entry_t             q_data,
  output logic                           q_pop,
  output logic                           clearing,
  output gdda_pkg::div_req_t             div_req,
  input  gdda_pkg::div_rsp_t             div_rsp,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit,
  output logic [gdda_pkg::PIX_W-1:0]     out_hit_x,
  output logic [gdda_pkg::PIX_W-1:0]     out_hit_y,
  output logic [gdda_pkg::FLD_W-1:0]     out_hit_col,
  output logic [gdda_pkg::FLD_W-1:0]     out_hit_row
);
  import gdda_pkg::*;

  localparam int DEPTH   = GRID_COLS * GRID_ROWS;
  localparam int AW      = $clog2(DEPTH);
  localparam int CB      = $clog2(GRID_COLS);
  localparam int RB      = $clog2(GRID_ROWS);
  localparam int TOT_MAX = COORD_FRAC_BITS + 15;
  localparam int IX_W    = POS_W + 8;
  localparam int WIDE_W  = IX_W + TOT_MAX;
  localparam int SQ_IT   = SQ_W / 2;
  localparam int SC_W    = $clog2(SQ_IT);

  // intersection in tile units back to saturated pixels
  function automatic logic [PIX_W-1:0] t2p(input logic signed [IX_W-1:0] t,
                                           input logic [TOT_W-1:0] tot);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(t[IX_W-2:0]) << TOT_MAX;
    w = w >> (DFRAC + TOT_MAX - int'(tot));
    if (t[IX_W-1]) begin
      return '0;
    end else if (w > WIDE_W'(PIX_MAX)) begin
      return PIX_MAX;
    end
    return w[PIX_W-1:0];
  endfunction

  bk_state_t state_r, state_nxt;

  logic              tile_r [DEPTH];
  logic              rd_data_r;
  logic [AW-1:0]     clr_addr_r;

  logic [POS_W-1:0]  ox_r, oy_r, ux_r, uy_r;
  logic              negx_r, negy_r;
  logic [SQ_W-1:0]   sq_r, v_r, r_r, bit_r;
  logic [SC_W-1:0]   scnt_r;
  logic [LEN_W-1:0]  len_r;
  logic [STEP_W-1:0] stepx_r, stepy_r;
  logic [CROSS_W-1:0] crossx_r, crossy_r, dist_r, offx_r, offy_r;
  logic signed [CELL_W-1:0] cellx_r, celly_r, ncellx, ncelly;
  logic [MUL_P_W-1:0] prod_r;

  logic               res_hit_r;
  logic [PIX_W-1:0]   res_x_r, res_y_r;
  logic [FLD_W-1:0]   res_col_r, res_row_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic [PIX_W-1:0]   out_x_r, out_y_r;
  logic [FLD_W-1:0]   out_col_r, out_row_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic               move_x, out_of_grid, at_limit, wr_in_grid, out_free;
  logic [SQ_W-1:0]    sq_t, r_new;
  logic [CROSS_W-1:0] limit;
  logic [DFRAC:0]     fracx, fracy;
  logic signed [IX_W-1:0] ix, iy;
  logic [TOT_W-1:0]   totx, toty;

  assign clearing = state_r == BK_CLEAR;
  assign out_free = ~out_valid_r | ~out_stall;
  assign limit    = CROSS_W'({cfg.max_dist, {DFRAC{1'b0}}});
  assign at_limit = dist_r >= limit;
  assign move_x   = crossx_r < crossy_r;
  assign sq_t     = r_r + bit_r;
  assign r_new    = (v_r >= sq_t) ? ((r_r >> 1) + bit_r) : (r_r >> 1);
  assign totx     = TOT_W'(COORD_FRAC_BITS) + TOT_W'(cfg.sx);
  assign toty     = TOT_W'(COORD_FRAC_BITS) + TOT_W'(cfg.sy);

  // distance to the first boundary on each axis
  assign fracx = negx_r ? {1'b0, ox_r[DFRAC-1:0]} : ((DFRAC+1)'(1) << DFRAC) - ox_r[DFRAC-1:0];
  assign fracy = negy_r ? {1'b0, oy_r[DFRAC-1:0]} : ((DFRAC+1)'(1) << DFRAC) - oy_r[DFRAC-1:0];

  assign ncellx = move_x ? (negx_r ? cellx_r - CELL_W'(1) : cellx_r + CELL_W'(1)) : cellx_r;
  assign ncelly = move_x ? celly_r : (negy_r ? celly_r - CELL_W'(1) : celly_r + CELL_W'(1));

  assign out_of_grid = cellx_r[CELL_W-1] || celly_r[CELL_W-1] ||
                       (cellx_r >= CELL_W'(GRID_COLS)) || (celly_r >= CELL_W'(GRID_ROWS));
  assign wr_in_grid  = (CB'(0) + {4'b0, q_data.col} < GRID_COLS) &&
                       ({4'b0, q_data.row} < GRID_ROWS);

  assign rd_addr = AW'(AW'(ncelly[RB-1:0]) * AW'(GRID_COLS)) + AW'(ncellx[CB-1:0]);
  assign wr_addr = AW'(AW'(q_data.row) * AW'(GRID_COLS)) + AW'(q_data.col);

  assign ix = negx_r ? IX_W'(ox_r) - IX_W'(offx_r) : IX_W'(ox_r) + IX_W'(offx_r);
  assign iy = negy_r ? IX_W'(oy_r) - IX_W'(offy_r) : IX_W'(oy_r) + IX_W'(offy_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR:   if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = BK_IDLE;
      BK_IDLE: begin
        if (!q_sts.empty) begin
          state_nxt = (q_data.kind == Q_CAST) ? BK_NORM : BK_OUT;
        end
      end
      BK_NORM: begin
        if (ux_r[POS_W-1:DIR_W] == '0 && uy_r[POS_W-1:DIR_W] == '0) begin
          state_nxt = BK_SQX;
        end
      end
      BK_SQX:     state_nxt = BK_SQY;
      BK_SQY:     state_nxt = BK_SQS;
      BK_SQS:     state_nxt = BK_SQRT;
      BK_SQRT: begin
        if (scnt_r == '0) begin
          state_nxt = (r_new == '0) ? BK_OUT : BK_DX_GO;
        end
      end
      BK_DX_GO:   state_nxt = (ux_r == '0) ? BK_DY_GO : BK_DX_WAIT;
      BK_DX_WAIT: if (div_rsp.done) state_nxt = BK_DY_GO;
      BK_DY_GO:   state_nxt = (uy_r == '0) ? BK_CRX : BK_DY_WAIT;
      BK_DY_WAIT: if (div_rsp.done) state_nxt = BK_CRX;
      BK_CRX:     state_nxt = BK_CRY;
      BK_CRY:     state_nxt = BK_CRD;
      BK_CRD:     state_nxt = BK_WALK;
      BK_WALK:    state_nxt = at_limit ? BK_OUT : BK_TEST;
      BK_TEST: begin
        if (out_of_grid) begin
          state_nxt = BK_OUT;
        end else if (rd_data_r) begin
          state_nxt = BK_MX;
        end else begin
          state_nxt = BK_WALK;
        end
      end
      BK_MX:      state_nxt = BK_OX_GO;
      BK_OX_GO:   state_nxt = BK_OX_WAIT;
      BK_OX_WAIT: if (div_rsp.done) state_nxt = BK_MY;
      BK_MY:      state_nxt = BK_OY_GO;
      BK_OY_GO:   state_nxt = BK_OY_WAIT;
      BK_OY_WAIT: if (div_rsp.done) state_nxt = BK_FIN;
      BK_FIN:     state_nxt = BK_OUT;
      BK_OUT:     if (out_free) state_nxt = BK_IDLE;
      default:    state_nxt = BK_CLEAR;
    endcase
  end

  // control outputs and shared multiplier operands
  always_comb begin
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = DIV_N_W'({len_r, {DFRAC{1'b0}}});
    div_req.den   = DIV_D_W'(ux_r[DIR_W-1:0]);
    mul_a         = ux_r[DIR_W-1:0];
    mul_b         = MUL_B_W'(ux_r[DIR_W-1:0]);
    case (state_r)
      BK_IDLE: begin
        q_pop = ~q_sts.empty;
        wr_en = ~q_sts.empty && (q_data.kind == Q_WRITE) && wr_in_grid;
      end
      BK_SQY: begin
        mul_a = uy_r[DIR_W-1:0];
        mul_b = MUL_B_W'(uy_r[DIR_W-1:0]);
      end
      BK_DX_GO:   div_req.start = ux_r != '0;
      BK_DY_GO: begin
        div_req.start = uy_r != '0;
        div_req.den   = DIV_D_W'(uy_r[DIR_W-1:0]);
      end
      BK_CRX: begin
        mul_a = MUL_A_W'(fracx);
        mul_b = stepx_r;
      end
      BK_CRY: begin
        mul_a = MUL_A_W'(fracy);
        mul_b = stepy_r;
      end
      BK_MX:      mul_b = MUL_B_W'(dist_r[DIST_W-1:0]);
      BK_MY: begin
        mul_a = uy_r[DIR_W-1:0];
        mul_b = MUL_B_W'(dist_r[DIST_W-1:0]);
      end
      BK_OX_GO, BK_OY_GO: begin
        div_req.start = 1'b1;
        div_req.num   = prod_r[DIV_N_W-1:0];
        div_req.den   = len_r;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == BK_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // tile map with registered read
  always_ff @(posedge clk) begin
    if (state_r == BK_CLEAR) begin
      tile_r[clr_addr_r] <= 1'b0;
    end else if (wr_en) begin
      tile_r[wr_addr] <= q_data.solid;
    end
    rd_data_r <= tile_r[rd_addr];
  end

  // ray datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      BK_IDLE: begin
        ox_r      <= q_data.ox;
        oy_r      <= q_data.oy;
        ux_r      <= q_data.ux;
        uy_r      <= q_data.uy;
        negx_r    <= q_data.negx;
        negy_r    <= q_data.negy;
        cellx_r   <= CELL_W'(q_data.ox[POS_W-1:DFRAC]);
        celly_r   <= CELL_W'(q_data.oy[POS_W-1:DFRAC]);
        res_hit_r <= 1'b0;
        res_x_r   <= '0;
        res_y_r   <= '0;
        res_col_r <= '0;
        res_row_r <= '0;
      end
      BK_NORM: begin
        if (ux_r[POS_W-1:DIR_W] != '0 || uy_r[POS_W-1:DIR_W] != '0) begin
          ux_r <= ux_r >> 1;
          uy_r <= uy_r >> 1;
        end
      end
      BK_SQY:     sq_r <= SQ_W'(prod_r);
      BK_SQS: begin
        v_r    <= sq_r + SQ_W'(prod_r);
        r_r    <= '0;
        bit_r  <= SQ_W'(1) << (SQ_W - 2);
        scnt_r <= SC_W'(SQ_IT - 1);
      end
      BK_SQRT: begin
        if (v_r >= sq_t) begin
          v_r <= v_r - sq_t;
        end
        r_r    <= r_new;
        bit_r  <= bit_r >> 2;
        scnt_r <= scnt_r - SC_W'(1);
        len_r  <= LEN_W'(r_new);
      end
      BK_DX_GO:   stepx_r <= STEP_CAP;
      BK_DX_WAIT: begin
        stepx_r <= (div_rsp.quo > DIV_N_W'(STEP_CAP)) ? STEP_CAP : div_rsp.quo[STEP_W-1:0];
      end
      BK_DY_GO:   stepy_r <= STEP_CAP;
      BK_DY_WAIT: begin
        stepy_r <= (div_rsp.quo > DIV_N_W'(STEP_CAP)) ? STEP_CAP : div_rsp.quo[STEP_W-1:0];
      end
      BK_CRY:     crossx_r <= CROSS_W'(prod_r >> DFRAC);
      BK_CRD: begin
        crossy_r <= CROSS_W'(prod_r >> DFRAC);
        dist_r   <= '0;
      end
      BK_WALK: begin
        if (!at_limit) begin
          cellx_r <= ncellx;
          celly_r <= ncelly;
          if (move_x) begin
            dist_r   <= crossx_r;
            crossx_r <= crossx_r + CROSS_W'(stepx_r);
          end else begin
            dist_r   <= crossy_r;
            crossy_r <= crossy_r + CROSS_W'(stepy_r);
          end
        end
      end
      BK_OX_WAIT: offx_r <= div_rsp.quo[CROSS_W-1:0];
      BK_OY_WAIT: offy_r <= div_rsp.quo[CROSS_W-1:0];
      BK_FIN: begin
        res_hit_r <= 1'b1;
        res_x_r   <= t2p(ix, totx);
        res_y_r   <= t2p(iy, toty);
        res_col_r <= cellx_r[FLD_W-1:0];
        res_row_r <= celly_r[FLD_W-1:0];
      end
      default: begin
        sq_r <= sq_r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == BK_OUT && out_free) begin
      out_hit_r <= res_hit_r;
      out_x_r   <= res_x_r;
      out_y_r   <= res_y_r;
      out_col_r <= res_col_r;
      out_row_r <= res_row_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_hit_x   = out_x_r;
  assign out_hit_y   = out_y_r;
  assign out_hit_col = out_col_r;
  assign out_hit_row = out_row_r;

endmodule

FILE: sv/gdda_checker.sv
module gdda_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_hit,
  input logic [gdda_pkg::PIX_W-1:0] out_hit_x,
  input logic [gdda_pkg::PIX_W-1:0] out_hit_y,
  input logic [gdda_pkg::FLD_W-1:0] out_hit_col,
  input logic [gdda_pkg::FLD_W-1:0] out_hit_row
);

  // a stalled result transaction stays valid and keeps its hit coordinates
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit_x) && $stable(out_hit_y))
    else $error("stalled result changed");

  // misses and writes carry all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_x == '0 && out_hit_y == '0 &&
                              out_hit_col == '0 && out_hit_row == '0)
    else $error("miss result not zero");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // tile map clear pass holds off input right after reset
  a_rst_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input accepted during clear pass");

endmodule

bind grid_dda_ray_cast_top gdda_checker u_chk (.*);
